### hw/rtl/tc_pkg.sv
// ----------------------------------------------------------------------------
// tc_pkg: shared types and constants of the triangle counter
// Field widths, command and status structs between controller and datapath,
// controller state encoding and the row population count.
// ----------------------------------------------------------------------------
package tc_pkg;

  localparam int NODE_W   = 6;
  localparam int CFG_W    = 7;
  localparam int COUNT_W  = 16;
  localparam int ROW_MAX  = 1 << NODE_W;
  localparam int PCNT_W   = NODE_W + 1;

  localparam logic [CFG_W-1:0]   NODE_COUNT_RST = 7'd64;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 16'hFFFF;

  localparam logic ACT_EDGE   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_WR2    = 8'b0000_0100,
    ST_READ_I = 8'b0000_1000,
    ST_SCAN   = 8'b0001_0000,
    ST_DRAIN1 = 8'b0010_0000,
    ST_DRAIN2 = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } tc_state_t;

  typedef enum logic [1:0] {
    WR_NONE   = 2'd0,
    WR_CLEAR  = 2'd1,
    WR_EDGE_A = 2'd2,
    WR_EDGE_B = 2'd3
  } wr_op_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_ROWI = 2'd1,
    RD_ROWJ = 2'd2
  } rd_op_t;

  typedef struct packed {
    wr_op_t            wr_op;
    rd_op_t            rd_op;
    logic [NODE_W-1:0] addr;
    logic              clr_total;
    logic              load_out;
  } tc_cmd_t;

  typedef struct packed {
    logic edge_ok;
  } tc_status_t;

  function automatic logic [PCNT_W-1:0] popcount_row(input logic [ROW_MAX-1:0] v);
    logic [PCNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < ROW_MAX; k++) begin
      n = n + PCNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

### hw/rtl/tc_in_if.sv
// ----------------------------------------------------------------------------
// tc_in_if: request channel into the triangle counter
// Valid/ready handshake carrying an edge or a finish request.
// ----------------------------------------------------------------------------
interface tc_in_if;
  import tc_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);

endinterface

### hw/rtl/tc_out_if.sv
// ----------------------------------------------------------------------------
// tc_out_if: result channel out of the triangle counter
// Valid/ready handshake carrying one triangle count per finish request.
// ----------------------------------------------------------------------------
interface tc_out_if;
  import tc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] triangle_count;

  modport source (output valid, triangle_count, input ready);
  modport sink   (input valid, triangle_count, output ready);

endinterface

### hw/rtl/graph_triangle_counter.sv
// ----------------------------------------------------------------------------
// graph_triangle_counter: triangle counter over an adjacency bit matrix
//
//   channel   dir  payload                      handshake
//   in_chan   in   action, node_a, node_b       valid/ready
//   out_chan  out  triangle_count               valid/ready
//   cfg_*     in   cfg_wdata (node_count)       cfg_we, no ready
//
// Edge request: an invalid edge is dropped on accept; a valid one is stored
// as its bit and then the mirrored bit, one matrix bit per cycle. Finish
// request: accept, (N-2) pivot reads, (N-1)(N-2)/2 neighbor reads, drain and
// result load, then a clearing pass over all N rows; N = min(MAX_NODES, 64).
// After reset the same clearing pass runs with in_chan.ready low.
// A waiting result stalls only the result load of the next finish request.
// ----------------------------------------------------------------------------
module graph_triangle_counter #(
  parameter int MAX_NODES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tc_in_if.sink                    in_chan,
  tc_out_if.source                 out_chan,
  input  logic                     cfg_we,
  input  logic [tc_pkg::CFG_W-1:0] cfg_wdata
);
  import tc_pkg::*;

  localparam int SPAN = (MAX_NODES < ROW_MAX) ? MAX_NODES : ROW_MAX;

  tc_cmd_t    cmd;
  tc_status_t status;
  logic       in_ready;

  tc_ctrl #(
    .SPAN (SPAN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tc_datapath #(
    .SPAN (SPAN)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_node_a (in_chan.node_a),
    .in_node_b (in_chan.node_b),
    .cmd       (cmd),
    .status    (status),
    .out_count (out_chan.triangle_count)
  );

  assign in_chan.ready = in_ready;

`ifndef NO_ASSERTIONS
  a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready && in_chan.action == ACT_FINISH) |=> !in_ready)
    else $error("input taken during counting walk");

  a_edge_second_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_ready && in_chan.action == ACT_EDGE && status.edge_ok)
      |=> (!in_ready && cmd.wr_op == WR_EDGE_B))
    else $error("mirror write of stored edge missing");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (int'(out_chan.triangle_count) <= SPAN * (SPAN - 1) * (SPAN - 2) / 6))
    else $error("triangle count above graph maximum");
`endif

endmodule

### hw/rtl/tc_datapath.sv
// ----------------------------------------------------------------------------
// tc_datapath: adjacency memory and counting pipeline
// Holds the node_count register and the bit matrix. Rows are read one per
// cycle; each neighbor row is ANDed with the pivot row above its column and
// population-counted into a saturating total.
// ----------------------------------------------------------------------------
module tc_datapath #(
  parameter int SPAN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tc_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [tc_pkg::NODE_W-1:0]   in_node_a,
  input  logic [tc_pkg::NODE_W-1:0]   in_node_b,
  input  tc_pkg::tc_cmd_t             cmd,
  output tc_pkg::tc_status_t          status,
  output logic [tc_pkg::COUNT_W-1:0]  out_count
);
  import tc_pkg::*;

  localparam int SPAN_W = $clog2(SPAN);

  logic [SPAN-1:0]    adj_mem [SPAN];

  logic [CFG_W-1:0]   node_count_r;
  logic [SPAN_W-1:0]  edge_a_r;
  logic [SPAN_W-1:0]  edge_b_r;
  logic [SPAN_W-1:0]  in_a;
  logic [SPAN_W-1:0]  in_b;
  logic [SPAN_W-1:0]  wr_row;
  logic [SPAN_W-1:0]  wr_col;
  logic [SPAN_W-1:0]  rd_addr;

  rd_op_t             rd_kind_r;
  logic [SPAN_W-1:0]  col_r;
  logic [SPAN-1:0]    rd_data_r;
  logic [SPAN-1:0]    row_i_r;
  logic [SPAN-1:0]    above;
  logic [SPAN-1:0]    prod_nxt;
  logic [SPAN-1:0]    prod_r;
  logic               prod_v_r;
  logic [PCNT_W-1:0]  prod_cnt;
  logic [COUNT_W:0]   total_sum;
  logic [COUNT_W-1:0] total_r;
  logic [COUNT_W-1:0] out_count_r;

  assign in_a = in_node_a[SPAN_W-1:0];
  assign in_b = in_node_b[SPAN_W-1:0];

  assign status.edge_ok = (in_node_a != in_node_b)
                       && ({1'b0, in_node_a} < node_count_r)
                       && ({1'b0, in_node_b} < node_count_r)
                       && (int'(in_node_a) < SPAN)
                       && (int'(in_node_b) < SPAN);

  always_comb begin
    case (cmd.wr_op)
      WR_EDGE_A: begin
        wr_row = in_a;
        wr_col = in_b;
      end
      WR_EDGE_B: begin
        wr_row = edge_b_r;
        wr_col = edge_a_r;
      end
      default: begin
        wr_row = cmd.addr[SPAN_W-1:0];
        wr_col = '0;
      end
    endcase
  end

  assign rd_addr = cmd.addr[SPAN_W-1:0];

  always_ff @(posedge clk) begin
    case (cmd.wr_op)
      WR_CLEAR:  adj_mem[wr_row] <= '0;
      WR_EDGE_A: adj_mem[wr_row][wr_col] <= 1'b1;
      WR_EDGE_B: adj_mem[wr_row][wr_col] <= 1'b1;
      default: ;
    endcase
    if (cmd.rd_op != RD_NONE) begin
      rd_data_r <= adj_mem[rd_addr];
    end
  end

  // nodes above the neighbor column, gated by the pivot-neighbor edge
  assign above    = ({SPAN{1'b1}} << col_r) << 1;
  assign prod_nxt = rd_data_r & row_i_r & above & {SPAN{row_i_r[col_r]}};
  assign prod_cnt = popcount_row(ROW_MAX'(prod_r));
  assign total_sum = {1'b0, total_r} + (COUNT_W+1)'(prod_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      rd_kind_r    <= RD_NONE;
      prod_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      rd_kind_r <= cmd.rd_op;
      prod_v_r  <= (rd_kind_r == RD_ROWJ);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_op == WR_EDGE_A) begin
      edge_a_r <= in_a;
      edge_b_r <= in_b;
    end
    col_r <= rd_addr;
    if (rd_kind_r == RD_ROWI) begin
      row_i_r <= rd_data_r;
    end
    prod_r <= prod_nxt;
    if (cmd.clr_total) begin
      total_r <= '0;
    end else if (prod_v_r) begin
      total_r <= total_sum[COUNT_W] ? COUNT_SAT : total_sum[COUNT_W-1:0];
    end
    if (cmd.load_out) begin
      out_count_r <= total_r;
    end
  end

  assign out_count = out_count_r;

endmodule

### hw/rtl/tc_ctrl.sv
// ----------------------------------------------------------------------------
// tc_ctrl: sequencer of the triangle counter
// Clears the matrix, stores edges, walks pivot and neighbor rows for the
// count, and owns the result valid flag.
// ----------------------------------------------------------------------------
module tc_ctrl #(
  parameter int SPAN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tc_pkg::tc_status_t status,
  output tc_pkg::tc_cmd_t    cmd
);
  import tc_pkg::*;

  localparam int SPAN_W = $clog2(SPAN);

  tc_state_t         state_r;
  tc_state_t         state_nxt;
  logic [SPAN_W-1:0] i_r;
  logic [SPAN_W-1:0] i_nxt;
  logic [SPAN_W-1:0] j_r;
  logic [SPAN_W-1:0] j_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.wr_op     = WR_NONE;
    cmd.rd_op     = RD_NONE;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_op = WR_CLEAR;
        cmd.addr  = NODE_W'(i_r);
        if (i_r == SPAN_W'(SPAN - 1)) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + SPAN_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_EDGE) begin
            if (status.edge_ok) begin
              cmd.wr_op = WR_EDGE_A;
              state_nxt = ST_WR2;
            end
          end else begin
            cmd.clr_total = 1'b1;
            i_nxt         = '0;
            state_nxt     = ST_READ_I;
          end
        end
      end
      ST_WR2: begin
        cmd.wr_op = WR_EDGE_B;
        state_nxt = ST_IDLE;
      end
      ST_READ_I: begin
        cmd.rd_op = RD_ROWI;
        cmd.addr  = NODE_W'(i_r);
        j_nxt     = i_r + SPAN_W'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_op = RD_ROWJ;
        cmd.addr  = NODE_W'(j_r);
        if (j_r == SPAN_W'(SPAN - 2)) begin
          if (i_r == SPAN_W'(SPAN - 3)) begin
            state_nxt = ST_DRAIN1;
          end else begin
            i_nxt     = i_r + SPAN_W'(1);
            state_nxt = ST_READ_I;
          end
        end else begin
          j_nxt = j_r + SPAN_W'(1);
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          i_nxt         = '0;
          state_nxt     = ST_CLEAR;
        end
      end
      default: begin
        i_nxt     = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### tb/sv/graph_triangle_counter_tb.sv
// ----------------------------------------------------------------------------
// graph_triangle_counter_tb: self-checking bench for the triangle counter
// Loads undirected graphs edge by edge and requests a count on each finish.
// A short directed table covers endpoint extremes, duplicates, self-loops,
// out-of-range endpoints and node_count changes during loading. Random graphs
// follow under several node_count settings and idle patterns, including a
// long result hold-off that backs the block up. Random counts are checked
// against an in-bench adjacency model, directed ones against typed counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module graph_triangle_counter_tb;
  import tc_pkg::*;

  localparam int GRAPH_NODES = 64;
  localparam int SETTLE      = 3 * GRAPH_NODES;
  localparam int HOLD_CYCLES = 6000;
  localparam int RAND_ITEMS  = 1950;
  localparam int DIR_STEPS   = 26;

  typedef enum logic [1:0] {
    OP_EDGE      = 2'd0,
    OP_FINISH    = 2'd1,
    OP_SET_NODES = 2'd2
  } step_op_t;

  typedef struct packed {
    step_op_t           op;
    logic [NODE_W-1:0]  a;
    logic [NODE_W-1:0]  b;
    logic [CFG_W-1:0]   nodes;
    logic               typed;
    logic [COUNT_W-1:0] count;
  } dir_step_t;

  // typed counts: empty graph, single triangles with endpoint extremes,
  // self-loop and duplicates, cleared matrix, edges kept across node_count
  dir_step_t dir_steps [DIR_STEPS] = '{
    '{OP_FINISH,    6'd0,  6'd0,  7'd0,   1'b1, 16'd0},
    '{OP_EDGE,      6'd0,  6'd63, 7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd63, 6'd0,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd0,  6'd1,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd63, 6'd1,  7'd0,   1'b0, 16'd0},
    '{OP_FINISH,    6'd63, 6'd63, 7'd0,   1'b1, 16'd1},
    '{OP_EDGE,      6'd5,  6'd5,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd5,  6'd6,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd6,  6'd7,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd7,  6'd5,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd6,  6'd5,  7'd0,   1'b0, 16'd0},
    '{OP_FINISH,    6'd0,  6'd0,  7'd0,   1'b1, 16'd1},
    '{OP_FINISH,    6'd0,  6'd0,  7'd0,   1'b1, 16'd0},
    '{OP_SET_NODES, 6'd0,  6'd0,  7'd4,   1'b0, 16'd0},
    '{OP_EDGE,      6'd0,  6'd4,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd0,  6'd1,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd1,  6'd2,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd2,  6'd0,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd3,  6'd63, 7'd0,   1'b0, 16'd0},
    '{OP_SET_NODES, 6'd0,  6'd0,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd0,  6'd3,  7'd0,   1'b0, 16'd0},
    '{OP_SET_NODES, 6'd0,  6'd0,  7'd127, 1'b0, 16'd0},
    '{OP_EDGE,      6'd1,  6'd3,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd0,  6'd3,  7'd0,   1'b0, 16'd0},
    '{OP_EDGE,      6'd62, 6'd63, 7'd0,   1'b0, 16'd0},
    '{OP_FINISH,    6'd0,  6'd0,  7'd0,   1'b1, 16'd2}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;

  tc_in_if  req_if ();
  tc_out_if res_if ();

  graph_triangle_counter #(
    .MAX_NODES (GRAPH_NODES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [GRAPH_NODES-1:0] graph_rows [GRAPH_NODES];
  logic [CFG_W-1:0]       nodes_in_use;
  logic [COUNT_W-1:0]     pending_counts [$];
  logic [COUNT_W-1:0]     want_count;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int errors;
  int requests_sent;
  int live_items;
  int counts_requested;
  int counts_seen;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("graph_triangle_counter_tb: errors");
    $finish;
  end

  function automatic void graph_clear();
    for (int k = 0; k < GRAPH_NODES; k++) begin
      graph_rows[k] = '0;
    end
  endfunction

  function automatic bit graph_add_edge(input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b);
    int limit;
    limit = (nodes_in_use < GRAPH_NODES) ? int'(nodes_in_use) : GRAPH_NODES;
    if (a != b && int'(a) < limit && int'(b) < limit) begin
      graph_rows[a][b] = 1'b1;
      graph_rows[b][a] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [COUNT_W-1:0] graph_count_triangles();
    int                     total;
    int                     i;
    int                     j;
    logic [GRAPH_NODES-1:0] upper;
    total = 0;
    for (i = 0; i < GRAPH_NODES; i++) begin
      for (j = i + 1; j < GRAPH_NODES; j++) begin
        if (graph_rows[i][j]) begin
          upper = {GRAPH_NODES{1'b1}} << (j + 1);
          total += $countones(graph_rows[i] & graph_rows[j] & upper);
        end
      end
    end
    return (total > int'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(total);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic offer_request(input logic act, input logic [NODE_W-1:0] a,
                               input logic [NODE_W-1:0] b, input logic typed,
                               input logic [COUNT_W-1:0] typed_count);
    logic [COUNT_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.node_a <= a;
    req_if.node_b <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    requests_sent++;
    if (act == ACT_FINISH) begin
      predicted = graph_count_triangles();
      graph_clear();
      pending_counts.insert(pending_counts.size(), typed ? typed_count : predicted);
      counts_requested++;
      live_items++;
    end else if (graph_add_edge(a, b)) begin
      live_items++;
    end
    @(negedge clk);
  endtask

  // node_count is only touched with nothing in flight
  task automatic apply_node_count(input logic [CFG_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we       <= 1'b0;
    nodes_in_use  = value;
    settings_used++;
  endtask

  task automatic report_fail(input string what, input logic [COUNT_W-1:0] expv,
                             input logic [COUNT_W-1:0] got);
    errors++;
    if (errors <= 10) begin
      $display("%t: %s: expected %0d, got %0d", $realtime, what, expv, got);
    end
  endtask

  // result receiver
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      counts_seen++;
      if (pending_counts.size() == 0) begin
        report_fail("count with no finish pending", '0, res_if.triangle_count);
      end else begin
        want_count = pending_counts.pop_front();
        if (res_if.triangle_count !== want_count) begin
          report_fail("triangle_count mismatch", want_count, res_if.triangle_count);
        end
      end
    end
  end

  initial begin
    int                r;
    int                ph;
    int                lim;
    int                span;
    int                base;
    int                n_edges;
    int                sent;
    int                budget;
    bit                cut;
    logic [CFG_W-1:0]  nc;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = NODE_COUNT_RST;
    req_if.valid     = 1'b0;
    req_if.action    = ACT_EDGE;
    req_if.node_a    = '0;
    req_if.node_b    = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_left        = 0;
    errors           = 0;
    requests_sent    = 0;
    live_items       = 0;
    counts_requested = 0;
    counts_seen      = 0;
    settings_used    = 0;
    nodes_in_use     = NODE_COUNT_RST;
    graph_clear();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIR_STEPS; r++) begin
      case (dir_steps[r].op)
        OP_SET_NODES: apply_node_count(dir_steps[r].nodes);
        OP_EDGE: offer_request(ACT_EDGE, dir_steps[r].a, dir_steps[r].b, 1'b0, '0);
        default: offer_request(ACT_FINISH, dir_steps[r].a, dir_steps[r].b,
                               dir_steps[r].typed, dir_steps[r].count);
      endcase
    end

    live_items = 0;
    ph         = 0;
    while (requests_sent < RAND_ITEMS) begin
      case (ph)
        0:       nc = 7'd64;
        1:       nc = 7'd3;
        2:       nc = 7'd0;
        3:       nc = 7'd127;
        4:       nc = 7'd1;
        5:       nc = 7'd2;
        default: nc = ($urandom_range(3) == 0) ? 7'd64 : CFG_W'($urandom_range(4, 64));
      endcase
      apply_node_count(nc);
      lim = (nc < GRAPH_NODES) ? int'(nc) : GRAPH_NODES;
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 80;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      // back-pressure: results pile up and the block stops taking requests
      if (ph == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
      end
      budget = (lim < 3) ? 20 : 200;
      sent   = 0;
      while (sent < budget && requests_sent < RAND_ITEMS) begin
        span = ($urandom_range(9) < 7) ? $urandom_range(3, 12) : $urandom_range(3, 64);
        if (span > lim) span = lim;
        base    = (lim > span) ? $urandom_range(lim - span) : 0;
        n_edges = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
        cut     = 1'b0;
        for (int e = 0; e < n_edges; e++) begin
          if (sent >= budget || requests_sent >= RAND_ITEMS) begin
            cut = 1'b1;
            break;
          end
          if (span >= 2 && $urandom_range(99) < 85) begin
            a = NODE_W'(base + $urandom_range(span - 1));
            b = NODE_W'(base + $urandom_range(span - 1));
          end else begin
            a = NODE_W'($urandom_range(63));
            b = ($urandom_range(3) == 0) ? a : NODE_W'($urandom_range(63));
          end
          offer_request(ACT_EDGE, a, b, 1'b0, '0);
          sent++;
        end
        if (!cut) begin
          offer_request(ACT_FINISH, NODE_W'($urandom_range(63)),
                        NODE_W'($urandom_range(63)), 1'b0, '0);
          sent++;
        end
      end
      ph++;
    end

    req_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d requests (%0d random live) over %0d node_count settings,",
             requests_sent, live_items, settings_used);
    $display("%0d of %0d triangle counts checked, incl. a %0d-cycle result hold-off",
             counts_seen, counts_requested, HOLD_CYCLES);
    if (errors == 0) begin
      $display("graph_triangle_counter_tb: clean");
    end else begin
      $display("graph_triangle_counter_tb: errors");
    end
    $finish;
  end

endmodule
